/* design/pva_pkg.sv */
package pva_pkg;

  localparam int ROT_STEPS = 16;
  localparam int TAB_LEN = 24;
  localparam int STEPS = (ROT_STEPS > TAB_LEN) ? TAB_LEN : ROT_STEPS;

  localparam int RAD_W = 16;
  localparam int ANG_W = 16;
  localparam int SUM_RAD_W = 17;
  localparam int SUM_ANG_W = 15;

  localparam int HALF_TURN = 180;
  localparam int ANG_FRAC = 6;
  localparam int INT_ANG_FRAC = 16;
  localparam int RAD_GUARD = 8;
  localparam int GAIN_FRAC = 30;

  localparam int XW = 29;
  localparam int ZW = 26;
  localparam int MAG_W = 28;
  localparam int GAIN_W = 32;

  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W = 19;
  localparam int QEST_W = 19;
  localparam int PROD_W = MAG_W + RECIP_W;
  localparam int NUM_W = 52;
  localparam int REM_W = 34;
  localparam int DIV_STAGES = 4;

  localparam int HALF_Q6 = HALF_TURN << ANG_FRAC;
  localparam int FULL_Q6 = 2 * HALF_Q6;
  localparam int QUARTER_Q6 = HALF_Q6 / 2;
  localparam int RADIUS_MAX = (1 << SUM_RAD_W) - 1;

  localparam int DEPTH = 2 * STEPS + 3 + DIV_STAGES;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [ZW-1:0] z;
  } start_t;

  function automatic logic signed [ZW-1:0] atan_q16(int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0: v = ZW'(2949120);
      1: v = ZW'(1740967);
      2: v = ZW'(919879);
      3: v = ZW'(466945);
      4: v = ZW'(234379);
      5: v = ZW'(117304);
      6: v = ZW'(58666);
      7: v = ZW'(29335);
      8: v = ZW'(14668);
      9: v = ZW'(7334);
      10: v = ZW'(3667);
      11: v = ZW'(1833);
      12: v = ZW'(917);
      13: v = ZW'(458);
      14: v = ZW'(229);
      15: v = ZW'(115);
      16: v = ZW'(57);
      17: v = ZW'(29);
      18: v = ZW'(14);
      19: v = ZW'(7);
      20: v = ZW'(4);
      21: v = ZW'(2);
      22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [GAIN_W-1:0] gain_sq();
    longint a;
    a = longint'(1) << GAIN_FRAC;
    for (int i = 0; i < STEPS; i++) begin
      a = a + (a >>> (2 * i));
    end
    return a[GAIN_W-1:0];
  endfunction

  localparam logic [GAIN_W-1:0] GAIN_SQ = gain_sq();

  localparam logic [RECIP_W-1:0] GAIN_RECIP =
    RECIP_W'((longint'(1) << (GAIN_FRAC - RAD_GUARD + RECIP_SHIFT)) / longint'(GAIN_SQ));

endpackage

/* design/pva_points_if.sv */
interface pva_points_if;
  logic valid;
  logic ready;
  logic [pva_pkg::RAD_W-1:0] first_radius;
  logic signed [pva_pkg::ANG_W-1:0] first_angle;
  logic [pva_pkg::RAD_W-1:0] second_radius;
  logic signed [pva_pkg::ANG_W-1:0] second_angle;

  modport source (output valid, first_radius, first_angle, second_radius, second_angle,
                  input ready);
  modport sink (input valid, first_radius, first_angle, second_radius, second_angle,
                output ready);
endinterface

/* design/pva_sum_if.sv */
interface pva_sum_if;
  logic valid;
  logic ready;
  logic [pva_pkg::SUM_RAD_W-1:0] sum_radius;
  logic signed [pva_pkg::SUM_ANG_W-1:0] sum_angle;

  modport source (output valid, sum_radius, sum_angle, input ready);
  modport sink (input valid, sum_radius, sum_angle, output ready);
endinterface

/* design/polar_vector_add.sv */
// Throughput: one transfer per cycle; each rotation and vectoring step is its own register
// stage, the gain removal takes four more, and a stage holds only while the stage after it
// is full and stalled.
// Reset: synchronous rst empties every stage; payload registers are not reset.
module polar_vector_add (
  input logic clk,
  input logic rst,
  pva_points_if.sink points,
  pva_sum_if.source result
);

  localparam int N = pva_pkg::STEPS;
  localparam int XW = pva_pkg::XW;
  localparam int ZW = pva_pkg::ZW;
  localparam int L = pva_pkg::DEPTH;
  localparam int D = pva_pkg::DIV_STAGES;
  localparam int VB = N + 1;
  localparam int FB = 2 * N + 2;

  localparam logic signed [ZW-1:0] HALF_Z =
    ZW'(pva_pkg::HALF_TURN * (1 << pva_pkg::INT_ANG_FRAC));
  localparam logic signed [ZW-1:0] ROUND_Z =
    ZW'(1 << (pva_pkg::INT_ANG_FRAC - pva_pkg::ANG_FRAC - 1));
  localparam logic signed [ZW-1:0] LIM_Z = ZW'(pva_pkg::HALF_Q6);
  localparam logic [pva_pkg::REM_W-1:0] ONE_GSQ = pva_pkg::REM_W'(pva_pkg::GAIN_SQ);
  localparam logic [pva_pkg::REM_W-1:0] TWO_GSQ = pva_pkg::REM_W'(pva_pkg::GAIN_SQ) << 1;

  logic [L-1:0] v;
  logic [L-1:0] en;

  logic signed [XW-1:0] rx1 [0:N];
  logic signed [XW-1:0] ry1 [0:N];
  logic signed [ZW-1:0] rz1 [0:N];
  logic signed [XW-1:0] rx2 [0:N];
  logic signed [XW-1:0] ry2 [0:N];
  logic signed [ZW-1:0] rz2 [0:N];

  logic signed [XW-1:0] vx [0:N];
  logic signed [XW-1:0] vy [0:N];
  logic signed [ZW-1:0] vz [0:N];
  logic signed [ZW-1:0] vbase [0:N];
  logic vzero [0:N];

  logic [pva_pkg::MAG_W-1:0] dmag;
  logic [pva_pkg::PROD_W-1:0] dprod;
  logic [pva_pkg::NUM_W-1:0] dnum1;
  logic [pva_pkg::NUM_W-1:0] dnum2;
  logic [pva_pkg::NUM_W-1:0] dback;
  logic [pva_pkg::QEST_W-1:0] dqest2;
  logic [pva_pkg::QEST_W-1:0] dqest3;
  logic [pva_pkg::REM_W-1:0] drem;
  logic [pva_pkg::QEST_W:0] quo;
  logic [pva_pkg::SUM_RAD_W-1:0] drad;
  logic signed [pva_pkg::SUM_ANG_W-1:0] dang [0:D];

  function automatic pva_pkg::start_t rect_start(logic [pva_pkg::RAD_W-1:0] r,
                                                 logic signed [pva_pkg::ANG_W-1:0] a);
    logic signed [pva_pkg::ANG_W:0] ang;
    pva_pkg::start_t s;
    ang = {a[pva_pkg::ANG_W-1], a};
    s.x = XW'({r, {pva_pkg::RAD_GUARD{1'b0}}});
    if (ang >= (pva_pkg::ANG_W+1)'(pva_pkg::HALF_Q6)) begin
      ang = ang - (pva_pkg::ANG_W+1)'(pva_pkg::FULL_Q6);
    end else if (ang < -(pva_pkg::ANG_W+1)'(pva_pkg::HALF_Q6)) begin
      ang = ang + (pva_pkg::ANG_W+1)'(pva_pkg::FULL_Q6);
    end
    if (ang > (pva_pkg::ANG_W+1)'(pva_pkg::QUARTER_Q6)) begin
      s.x = -s.x;
      ang = ang - (pva_pkg::ANG_W+1)'(pva_pkg::HALF_Q6);
    end else if (ang < -(pva_pkg::ANG_W+1)'(pva_pkg::QUARTER_Q6)) begin
      s.x = -s.x;
      ang = ang + (pva_pkg::ANG_W+1)'(pva_pkg::HALF_Q6);
    end
    s.z = ZW'(ang) <<< (pva_pkg::INT_ANG_FRAC - pva_pkg::ANG_FRAC);
    return s;
  endfunction

  assign en[L-1] = !v[L-1] || result.ready;
  for (genvar s = 0; s < L - 1; s++) begin : g_en
    assign en[s] = !v[s] || en[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= points.valid;
      end
      for (int s = 1; s < L; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  assign points.ready = en[0];

  pva_pkg::start_t st1;
  pva_pkg::start_t st2;
  assign st1 = rect_start(points.first_radius, points.first_angle);
  assign st2 = rect_start(points.second_radius, points.second_angle);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rx1[0] <= st1.x;
      ry1[0] <= '0;
      rz1[0] <= st1.z;
      rx2[0] <= st2.x;
      ry2[0] <= '0;
      rz2[0] <= st2.z;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] AT = pva_pkg::atan_q16(i);
    always_ff @(posedge clk) begin
      if (en[1+i]) begin
        if (rz1[i] >= 0) begin
          rx1[i+1] <= rx1[i] - (ry1[i] >>> i);
          ry1[i+1] <= ry1[i] + (rx1[i] >>> i);
          rz1[i+1] <= rz1[i] - AT;
        end else begin
          rx1[i+1] <= rx1[i] + (ry1[i] >>> i);
          ry1[i+1] <= ry1[i] - (rx1[i] >>> i);
          rz1[i+1] <= rz1[i] + AT;
        end
        if (rz2[i] >= 0) begin
          rx2[i+1] <= rx2[i] - (ry2[i] >>> i);
          ry2[i+1] <= ry2[i] + (rx2[i] >>> i);
          rz2[i+1] <= rz2[i] - AT;
        end else begin
          rx2[i+1] <= rx2[i] + (ry2[i] >>> i);
          ry2[i+1] <= ry2[i] - (rx2[i] >>> i);
          rz2[i+1] <= rz2[i] + AT;
        end
      end
    end
  end

  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] sy;
  assign sx = rx1[N] + rx2[N];
  assign sy = ry1[N] + ry2[N];

  always_ff @(posedge clk) begin
    if (en[VB]) begin
      vz[0] <= '0;
      vzero[0] <= (sx == 0) && (sy == 0);
      if (sx < 0) begin
        vx[0] <= -sx;
        vy[0] <= -sy;
        vbase[0] <= (sy >= 0) ? HALF_Z : -HALF_Z;
      end else begin
        vx[0] <= sx;
        vy[0] <= sy;
        vbase[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [ZW-1:0] AT = pva_pkg::atan_q16(i);
    always_ff @(posedge clk) begin
      if (en[VB+1+i]) begin
        vbase[i+1] <= vbase[i];
        vzero[i+1] <= vzero[i];
        if (vy[i] < 0) begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - AT;
        end else begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + AT;
        end
      end
    end
  end

  logic [pva_pkg::MAG_W-1:0] mag;
  logic signed [ZW-1:0] zsum;
  logic signed [ZW-1:0] zq;
  logic signed [ZW-1:0] zc;

  always_comb begin
    mag = (vx[N] > 0) ? vx[N][pva_pkg::MAG_W-1:0] : '0;
    zsum = vbase[N] + vz[N] + ROUND_Z;
    zq = zsum >>> (pva_pkg::INT_ANG_FRAC - pva_pkg::ANG_FRAC);
    if (vzero[N]) begin
      zc = '0;
    end else if (zq > LIM_Z) begin
      zc = LIM_Z;
    end else if (zq < -LIM_Z) begin
      zc = -LIM_Z;
    end else begin
      zc = zq;
    end
  end

  always_ff @(posedge clk) begin
    if (en[FB]) begin
      dmag <= mag;
      dang[0] <= zc[pva_pkg::SUM_ANG_W-1:0];
    end
  end

  // The reciprocal estimate is at most two below the rounded quotient; the remainder
  // check adds the missing units.
  always_ff @(posedge clk) begin
    if (en[FB+1]) begin
      dprod <= pva_pkg::PROD_W'(dmag) * pva_pkg::PROD_W'(pva_pkg::GAIN_RECIP);
      dnum1 <= pva_pkg::NUM_W'({dmag, {(pva_pkg::GAIN_FRAC - pva_pkg::RAD_GUARD){1'b0}}})
               + pva_pkg::NUM_W'(pva_pkg::GAIN_SQ >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[FB+2]) begin
      dqest2 <= dprod[pva_pkg::PROD_W-1:pva_pkg::RECIP_SHIFT];
      dback <= pva_pkg::NUM_W'(dprod[pva_pkg::PROD_W-1:pva_pkg::RECIP_SHIFT])
               * pva_pkg::NUM_W'(pva_pkg::GAIN_SQ);
      dnum2 <= dnum1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[FB+3]) begin
      drem <= pva_pkg::REM_W'(dnum2 - dback);
      dqest3 <= dqest2;
    end
  end

  always_comb begin
    if (drem >= TWO_GSQ) begin
      quo = {1'b0, dqest3} + (pva_pkg::QEST_W+1)'(2);
    end else if (drem >= ONE_GSQ) begin
      quo = {1'b0, dqest3} + (pva_pkg::QEST_W+1)'(1);
    end else begin
      quo = {1'b0, dqest3};
    end
  end

  always_ff @(posedge clk) begin
    if (en[FB+4]) begin
      drad <= (quo > (pva_pkg::QEST_W+1)'(pva_pkg::RADIUS_MAX)) ?
              pva_pkg::SUM_RAD_W'(pva_pkg::RADIUS_MAX) :
              quo[pva_pkg::SUM_RAD_W-1:0];
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_ang
    always_ff @(posedge clk) begin
      if (en[FB+1+k]) begin
        dang[k+1] <= dang[k];
      end
    end
  end

  assign result.valid = v[L-1];
  assign result.sum_angle = dang[D];
  assign result.sum_radius = drad;

endmodule

/* test/tb_polar_vector_add.sv */
module tb_polar_vector_add;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [pva_pkg::RAD_W-1:0] r1;
    logic signed [pva_pkg::ANG_W-1:0] a1;
    logic [pva_pkg::RAD_W-1:0] r2;
    logic signed [pva_pkg::ANG_W-1:0] a2;
  } point_pair_t;

  typedef struct {
    logic [pva_pkg::SUM_RAD_W-1:0] radius;
    logic signed [pva_pkg::SUM_ANG_W-1:0] angle;
  } vector_sum_t;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 2 * pva_pkg::STEPS + 40;

  localparam longint ARCTAN_DEG[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk;
  logic rst;

  pva_points_if pts ();
  pva_sum_if sums ();

  polar_vector_add u_dut (
    .clk(clk),
    .rst(rst),
    .points(pts),
    .result(sums)
  );

  point_pair_t pending_pairs[$];
  vector_sum_t expected_sums[$];
  int fail_count = 0;
  int send_gap = 0;
  int stall_len = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  function automatic void polar_to_rect(input logic [pva_pkg::RAD_W-1:0] r,
                                        input logic signed [pva_pkg::ANG_W-1:0] a,
                                        output longint x, output longint y);
    longint z, dx, dy;
    int ang;
    x = longint'(r) << pva_pkg::RAD_GUARD;
    y = 0;
    ang = int'(a);
    while (ang >= pva_pkg::HALF_Q6) ang -= pva_pkg::FULL_Q6;
    while (ang < -pva_pkg::HALF_Q6) ang += pva_pkg::FULL_Q6;
    if (ang > pva_pkg::QUARTER_Q6) begin
      x = -x;
      ang -= pva_pkg::HALF_Q6;
    end else if (ang < -pva_pkg::QUARTER_Q6) begin
      x = -x;
      ang += pva_pkg::HALF_Q6;
    end
    z = longint'(ang) << (pva_pkg::INT_ANG_FRAC - pva_pkg::ANG_FRAC);
    for (int i = 0; i < pva_pkg::STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_DEG[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_DEG[i];
      end
    end
  endfunction

  function automatic vector_sum_t predict_sum(point_pair_t p);
    vector_sum_t s;
    longint x1, y1, x2, y2, x, y, z, dx, dy, base, q, gain, mag, rad;
    polar_to_rect(p.r1, p.a1, x1, y1);
    polar_to_rect(p.r2, p.a2, x2, y2);
    x = x1 + x2;
    y = y1 + y2;
    if (x == 0 && y == 0) begin
      s.radius = '0;
      s.angle = '0;
      return s;
    end
    base = 0;
    z = 0;
    gain = longint'(1) << pva_pkg::GAIN_FRAC;
    if (x < 0) begin
      base = (y >= 0) ? (longint'(pva_pkg::HALF_TURN) << pva_pkg::INT_ANG_FRAC)
                      : -(longint'(pva_pkg::HALF_TURN) << pva_pkg::INT_ANG_FRAC);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < pva_pkg::STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_DEG[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_DEG[i];
      end
      gain += gain >> (2 * i);
    end
    mag = (x > 0) ? x : 0;
    rad = ((mag << (pva_pkg::GAIN_FRAC - pva_pkg::RAD_GUARD)) + gain / 2) / gain;
    if (rad > pva_pkg::RADIUS_MAX) rad = pva_pkg::RADIUS_MAX;
    q = (base + z + (longint'(1) << (pva_pkg::INT_ANG_FRAC - pva_pkg::ANG_FRAC - 1)))
        >>> (pva_pkg::INT_ANG_FRAC - pva_pkg::ANG_FRAC);
    if (q > pva_pkg::HALF_Q6) q = pva_pkg::HALF_Q6;
    if (q < -pva_pkg::HALF_Q6) q = -pva_pkg::HALF_Q6;
    s.radius = rad[pva_pkg::SUM_RAD_W-1:0];
    s.angle = q[pva_pkg::SUM_ANG_W-1:0];
    return s;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(string what);
    fail_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic add_pair(int r1, int a1, int r2, int a2);
    point_pair_t p;
    p.r1 = r1[pva_pkg::RAD_W-1:0];
    p.a1 = a1[pva_pkg::ANG_W-1:0];
    p.r2 = r2[pva_pkg::RAD_W-1:0];
    p.a2 = a2[pva_pkg::ANG_W-1:0];
    pending_pairs.push_back(p);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      pts.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (pts.valid && pts.ready)
        expected_sums.push_back(predict_sum('{pts.first_radius, pts.first_angle,
                                              pts.second_radius, pts.second_angle}));
      if (!pts.valid || pts.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          pts.valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          point_pair_t p;
          p = pending_pairs.pop_front();
          pts.valid <= 1'b1;
          pts.first_radius <= p.r1;
          pts.first_angle <= p.a1;
          pts.second_radius <= p.r2;
          pts.second_angle <= p.a2;
          send_gap <= pick_gap();
        end else begin
          pts.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sums.ready <= 1'b0;
      stall_len <= 0;
    end else begin
      if (sums.valid && sums.ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("transfer with no expected result");
        end else begin
          vector_sum_t e;
          e = expected_sums.pop_front();
          if (sums.sum_radius !== e.radius)
            report_mismatch($sformatf("sum_radius %0d, expected %0d",
                                      sums.sum_radius, e.radius));
          if (sums.sum_angle !== e.angle)
            report_mismatch($sformatf("sum_angle %0d, expected %0d",
                                      sums.sum_angle, e.angle));
        end
      end
      if (stall_len > 0) begin
        stall_len <= stall_len - 1;
        sums.ready <= 1'b0;
      end else begin
        sums.ready <= 1'b1;
        stall_len <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pts.valid && pts.ready) || (sums.valid && sums.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("polar_vector_add verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r, a, kind;
    rst = 1'b1;
    pts.valid = 1'b0;
    pts.first_radius = '0;
    pts.first_angle = '0;
    pts.second_radius = '0;
    pts.second_angle = '0;
    sums.ready = 1'b0;

    add_pair(0, 0, 0, 0);
    add_pair(65535, 0, 65535, 0);
    add_pair(65535, 23040, 65535, -23040);
    add_pair(65535, -32768, 65535, 32767);
    add_pair(256, 5760, 256, -5760);
    add_pair(256, 11520, 256, 0);
    add_pair(1000, -11520, 500, 11520);
    add_pair(65535, 11520, 0, 0);
    add_pair(300, 8000, 200, 9000);
    add_pair(300, -8000, 200, -9000);
    add_pair(5000, 11519, 5000, -11519);
    add_pair(65535, 5761, 65535, -5761);
    add_pair(1, 0, 0, 0);
    add_pair(0, 0, 1, 11520);
    add_pair(4096, 1000, 4096, 1000 - 11520);
    add_pair(777, 23039, 777, 11519);
    add_pair(43690, 21845, 21845, -21846);
    add_pair(65535, 17280, 65535, -17280);
    add_pair(0, 32767, 0, -32768);
    add_pair(65535, 12000, 1, -12000);

    for (int i = 0; i < 400; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        add_pair($urandom_range(0, 65535), $urandom_range(0, 46080) - 23040,
                 $urandom_range(0, 65535), $urandom_range(0, 46080) - 23040);
      end else if (kind < 8) begin
        add_pair($urandom, $urandom, $urandom, $urandom);
      end else if (kind < 9) begin
        r = $urandom_range(0, 65535);
        a = $urandom_range(0, 23040) - 11520;
        add_pair(r, a, r, (a >= 0) ? a - 11520 : a + 11520);
      end else begin
        add_pair($urandom_range(0, 15), $urandom_range(0, 46080) - 23040,
                 $urandom_range(0, 15), $urandom_range(0, 46080) - 23040);
      end
      if (i == 150) add_pair(0, 0, 0, 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    repeat (2000) @(posedge clk);
    gaps_on = 1'b0;
    repeat (300) @(posedge clk);
    gaps_on = 1'b1;

    do @(posedge clk);
    while (pending_pairs.size() != 0 || pts.valid || expected_sums.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("polar_vector_add verification clean");
    else
      $display("polar_vector_add verification failed");
    $finish;
  end
endmodule
